FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the fixed-point ALU.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication checked after the delay given by dly
`define ASSERT_DELAY(lbl, clk, rst, ante, dly, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Mode codes and shared types of the fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;
   localparam int FIELD_W = 32;
   localparam int MODE_W  = 4;

   localparam logic [MODE_W-1:0] MODE_ADD  = 4'd0;
   localparam logic [MODE_W-1:0] MODE_SUB  = 4'd1;
   localparam logic [MODE_W-1:0] MODE_MUL  = 4'd2;
   localparam logic [MODE_W-1:0] MODE_DIV  = 4'd3;
   localparam logic [MODE_W-1:0] MODE_GT   = 4'd4;
   localparam logic [MODE_W-1:0] MODE_GE   = 4'd5;
   localparam logic [MODE_W-1:0] MODE_LT   = 4'd6;
   localparam logic [MODE_W-1:0] MODE_LE   = 4'd7;
   localparam logic [MODE_W-1:0] MODE_EQ   = 4'd8;
   localparam logic [MODE_W-1:0] MODE_NE   = 4'd9;
   localparam logic [MODE_W-1:0] MODE_INC  = 4'd10;
   localparam logic [MODE_W-1:0] MODE_DEC  = 4'd11;
   localparam logic [MODE_W-1:0] MODE_MIN  = 4'd12;
   localparam logic [MODE_W-1:0] MODE_MAX  = 4'd13;
   localparam logic [MODE_W-1:0] MODE_FINT = 4'd14;
   localparam logic [MODE_W-1:0] MODE_TINT = 4'd15;

   // Sideband that travels with each word down the pipeline
   typedef struct packed {
      logic               is_div;
      logic               neg;
      logic               dz;
      logic               cmp;
      logic [FIELD_W-1:0] val;
   } fpa_side_type;
endpackage
`default_nettype wire

FILE: hdl/fpa_prep.sv
// ----------------------------------------------------------------------------
// fpa_prep
// First stage: decode, simple ALU ops, full product and divide operands.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_prep #(
   parameter int FRAC_BITS  = 8,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  in_valid,
   input  wire logic [fpa_pkg::MODE_W-1:0]            mode,
   input  wire logic signed [fpa_pkg::FIELD_W-1:0]    operand_a,
   input  wire logic signed [fpa_pkg::FIELD_W-1:0]    operand_b,
   output logic                                       valid_ff,
   output fpa_pkg::fpa_side_type                      side_ff,
   output logic                                       is_mul_ff,
   output logic signed [2*((DATA_WIDTH < 32) ? DATA_WIDTH : 32)-1:0] prod_ff,
   output logic [((DATA_WIDTH < 32) ? DATA_WIDTH : 32)+FRAC_BITS:0]  dmag_ff,
   output logic [((DATA_WIDTH < 32) ? DATA_WIDTH : 32):0]            bmag_ff
);
   import fpa_pkg::*;

   localparam int EW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
   localparam int BW = EW + 1;
   localparam int QW = EW + 1 + FRAC_BITS;

   logic signed [EW-1:0]   a_s, b_s;
   logic signed [BW-1:0]   a_x, b_x;
   logic [BW-1:0]          a_mag;
   logic [EW-1:0]          val_e;
   logic                   cmp_e, lt, gt;
   logic signed [2*EW-1:0] prod_in;
   fpa_side_type           side_in;

   function automatic logic signed [EW-1:0] a_s_from(input logic [FIELD_W-1:0] x);
      return x[EW-1:0];
   endfunction

   assign a_s = a_s_from(operand_a);
   assign b_s = a_s_from(operand_b);
   assign a_x = BW'(a_s);
   assign b_x = BW'(b_s);
   assign lt  = a_s < b_s;
   assign gt  = b_s < a_s;

   // Evaluate the modes that need neither the product nor the divider
   always_comb begin
      val_e = '0;
      cmp_e = 1'b0;
      unique case (mode)
         MODE_ADD:  val_e = a_s + b_s;
         MODE_SUB:  val_e = a_s - b_s;
         MODE_MUL:  val_e = '0;
         MODE_DIV:  val_e = '0;
         MODE_GT:   cmp_e = gt;
         MODE_GE:   cmp_e = !lt;
         MODE_LT:   cmp_e = lt;
         MODE_LE:   cmp_e = !gt;
         MODE_EQ:   cmp_e = (a_s == b_s);
         MODE_NE:   cmp_e = (a_s != b_s);
         MODE_INC:  val_e = a_s + EW'(1);
         MODE_DEC:  val_e = a_s - EW'(1);
         MODE_MIN:  val_e = lt ? a_s : b_s;
         MODE_MAX:  val_e = gt ? a_s : b_s;
         MODE_FINT: val_e = a_s << FRAC_BITS;
         MODE_TINT: val_e = a_s >>> FRAC_BITS;
         default:   val_e = '0;
      endcase
   end

   assign prod_in        = a_s * b_s;
   assign a_mag          = a_s[EW-1] ? BW'(-a_x) : BW'(a_x);
   assign side_in.is_div = (mode == MODE_DIV);
   assign side_in.neg    = a_s[EW-1] ^ b_s[EW-1];
   assign side_in.dz     = (mode == MODE_DIV) && (b_s == '0);
   assign side_in.cmp    = cmp_e;
   assign side_in.val    = FIELD_W'(val_e);

   // Advance the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // Capture the payload
   always_ff @(posedge clock) begin
      side_ff   <= side_in;
      is_mul_ff <= (mode == MODE_MUL);
      prod_ff   <= prod_in;
      dmag_ff   <= QW'(a_mag) << FRAC_BITS;
      bmag_ff   <= b_s[EW-1] ? BW'(-b_x) : BW'(b_x);
   end
endmodule
`default_nettype wire

FILE: hdl/fpa_align.sv
// ----------------------------------------------------------------------------
// fpa_align
// Second stage: scale the product and pass the sideband on to the divider.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_align #(
   parameter int FRAC_BITS  = 8,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   valid_i,
   input  wire fpa_pkg::fpa_side_type  side_i,
   input  wire logic                   is_mul_i,
   input  wire logic signed [2*((DATA_WIDTH < 32) ? DATA_WIDTH : 32)-1:0] prod_i,
   output logic                        valid_ff,
   output fpa_pkg::fpa_side_type       side_ff
);
   import fpa_pkg::*;

   localparam int EW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

   logic signed [2*EW-1:0] prod_sh;
   fpa_side_type           side_in;

   // Shift the product right arithmetically and keep the low bits
   assign prod_sh = prod_i >>> FRAC_BITS;

   always_comb begin
      side_in = side_i;
      if (is_mul_i) begin
         side_in.val = FIELD_W'(prod_sh[EW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= side_in;
   end
endmodule
`default_nettype wire

FILE: hdl/fpa_div_step.sv
// ----------------------------------------------------------------------------
// fpa_div_step
// One restoring divide step: one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_div_step #(
   parameter int QW = 41,
   parameter int BW = 33
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  valid_i,
   input  wire fpa_pkg::fpa_side_type side_i,
   input  wire logic [BW-1:0]         rem_i,
   input  wire logic [QW-1:0]         dq_i,
   input  wire logic [BW-1:0]         bmag_i,
   output logic                       valid_ff,
   output fpa_pkg::fpa_side_type      side_ff,
   output logic [BW-1:0]              rem_ff,
   output logic [QW-1:0]              dq_ff,
   output logic [BW-1:0]              bmag_ff
);
   import fpa_pkg::*;

   logic [BW:0] trial;
   logic        fits;

   // Bring down the next dividend bit and try the subtract
   assign trial = {rem_i, dq_i[QW-1]};
   assign fits  = trial >= {1'b0, bmag_i};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= side_i;
      rem_ff  <= fits ? BW'(trial - {1'b0, bmag_i}) : BW'(trial);
      dq_ff   <= {dq_i[QW-2:0], fits};
      bmag_ff <= bmag_i;
   end
endmodule
`default_nettype wire

FILE: hdl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Pipelined signed fixed-point ALU with a bit-per-stage divider.
// ----------------------------------------------------------------------------
//  channel   | ports                                        | handshake
//  request   | req_mode, req_operand_a, req_operand_b        | start, busy
//  response  | rsp_value, rsp_compare_true, rsp_div_by_zero  | rsp_valid strobe
//
//  One word is taken every cycle; busy is high only during reset.
//  Every mode passes the same registers: prep, align, the divider chain (one
//  quotient bit per stage) and the response register.
//  Reset clears all valid bits; payload registers are not reset.
//  The response strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none
module fixed_point_alu #(
   parameter int FRAC_BITS  = 8,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [fpa_pkg::MODE_W-1:0]         req_mode,
   input  wire logic signed [fpa_pkg::FIELD_W-1:0] req_operand_a,
   input  wire logic signed [fpa_pkg::FIELD_W-1:0] req_operand_b,
   output logic                                    rsp_valid,
   output logic signed [fpa_pkg::FIELD_W-1:0]      rsp_value,
   output logic                                    rsp_compare_true,
   output logic                                    rsp_div_by_zero
);
   import fpa_pkg::*;
   `include "assert_macros.svh"

   localparam int EW  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
   localparam int BW  = EW + 1;
   localparam int QW  = EW + 1 + FRAC_BITS;
   localparam int LAT = QW + 3;

   logic                   in_valid;
   logic                   p1_valid;
   fpa_side_type           p1_side;
   logic                   p1_is_mul;
   logic signed [2*EW-1:0] p1_prod;
   logic [QW-1:0]          p1_dmag;
   logic [BW-1:0]          p1_bmag;
   logic                   p2_valid;
   fpa_side_type           p2_side;
   logic [QW-1:0]          p2_dmag_ff;
   logic [BW-1:0]          p2_bmag_ff;

   logic                   dv_valid [0:QW];
   fpa_side_type           dv_side  [0:QW];
   logic [BW-1:0]          dv_rem   [0:QW];
   logic [QW-1:0]          dv_dq    [0:QW];
   logic [BW-1:0]          dv_bmag  [0:QW];

   logic [EW-1:0]          quo;
   logic [EW-1:0]          quo_s;
   logic [FIELD_W-1:0]     value_in;
   logic                   rsp_valid_ff;
   logic [FIELD_W-1:0]     rsp_value_ff;
   logic                   rsp_cmp_ff;
   logic                   rsp_dz_ff;

   assign busy     = reset;
   assign in_valid = start && !busy;

   fpa_prep #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .mode      (req_mode),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .valid_ff  (p1_valid),
      .side_ff   (p1_side),
      .is_mul_ff (p1_is_mul),
      .prod_ff   (p1_prod),
      .dmag_ff   (p1_dmag),
      .bmag_ff   (p1_bmag)
   );

   fpa_align #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_align (
      .clock    (clock),
      .reset    (reset),
      .valid_i  (p1_valid),
      .side_i   (p1_side),
      .is_mul_i (p1_is_mul),
      .prod_i   (p1_prod),
      .valid_ff (p2_valid),
      .side_ff  (p2_side)
   );

   // Hold the divide operands alongside the align stage
   always_ff @(posedge clock) begin
      p2_dmag_ff <= p1_dmag;
      p2_bmag_ff <= p1_bmag;
   end

   assign dv_valid[0] = p2_valid;
   assign dv_side[0]  = p2_side;
   assign dv_rem[0]   = '0;
   assign dv_dq[0]    = p2_dmag_ff;
   assign dv_bmag[0]  = p2_bmag_ff;

   // Divider chain, one quotient bit per stage
   for (genvar i = 0; i < QW; i++) begin : g_div
      fpa_div_step #(.QW(QW), .BW(BW)) u_step (
         .clock    (clock),
         .reset    (reset),
         .valid_i  (dv_valid[i]),
         .side_i   (dv_side[i]),
         .rem_i    (dv_rem[i]),
         .dq_i     (dv_dq[i]),
         .bmag_i   (dv_bmag[i]),
         .valid_ff (dv_valid[i+1]),
         .side_ff  (dv_side[i+1]),
         .rem_ff   (dv_rem[i+1]),
         .dq_ff    (dv_dq[i+1]),
         .bmag_ff  (dv_bmag[i+1])
      );
   end

   // Sign the quotient and pick the final value
   assign quo   = dv_dq[QW][EW-1:0];
   assign quo_s = dv_side[QW].neg ? EW'(-quo) : quo;

   always_comb begin
      priority if (dv_side[QW].dz) begin
         value_in = '0;
      end else if (dv_side[QW].is_div) begin
         value_in = FIELD_W'(quo_s);
      end else begin
         value_in = dv_side[QW].val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid[QW];
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= value_in;
      rsp_cmp_ff   <= dv_side[QW].cmp;
      rsp_dz_ff    <= dv_side[QW].dz;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_compare_true = rsp_cmp_ff;
   assign rsp_div_by_zero  = rsp_dz_ff;

   `ASSERT_DELAY(a_word_out, clock, reset, in_valid, LAT, rsp_valid)
   `ASSERT_DELAY(a_dz_flag, clock, reset, in_valid && (req_mode == MODE_DIV) && (req_operand_b[EW-1:0] == '0), LAT, rsp_div_by_zero)
   `ASSERT_IMPL(a_dz_zero, clock, reset, rsp_valid && rsp_div_by_zero, rsp_value == '0)
   `ASSERT_IMPL(a_flag_excl, clock, reset, rsp_valid, !(rsp_compare_true && rsp_div_by_zero))
endmodule
`default_nettype wire
